// ===== hdl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the deframer RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/nsdf_pkg.sv =====
// ----------------------------------------------------------------------------
// nsdf_pkg
// Types and constants shared by the netstring stream deframer.
// ----------------------------------------------------------------------------
package nsdf_pkg;

    localparam int unsigned LEN_W = 30;

    localparam logic [7:0] CHAR_COLON = 8'h3A;
    localparam logic [7:0] CHAR_COMMA = 8'h2C;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;

    localparam logic [LEN_W-1:0] LEN_MAX     = {LEN_W{1'b1}};
    localparam logic [LEN_W-1:0] LEN_RESET   = 30'd999999999;

    // Parser phase
    typedef enum logic [1:0] {
        PH_LEN     = 2'd0,
        PH_PAYLOAD = 2'd1,
        PH_COMMA   = 2'd2,
        PH_SKIP    = 2'd3
    } phase_t;

    // Result kind
    typedef enum logic [1:0] {
        KIND_NONE = 2'd0,
        KIND_BYTE = 2'd1,
        KIND_DONE = 2'd2,
        KIND_ERR  = 2'd3
    } kind_t;

    // Result status
    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_FORMAT = 2'd1,
        ST_RANGE  = 2'd2
    } status_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       is_last;
    } in_item_t;

    typedef struct packed {
        kind_t            out_kind;
        logic [7:0]       payload_byte;
        status_t          status;
        logic [LEN_W-1:0] payload_length;
        logic [LEN_W-1:0] consumed_count;
    } out_item_t;

endpackage

// ===== hdl/netstring_stream_deframer.sv =====
// ----------------------------------------------------------------------------
// netstring_stream_deframer
// Parses netstrings (length, colon, payload, comma) from a byte stream.
// ----------------------------------------------------------------------------
// One byte is taken per cycle, back to back, for as long as the output side
// keeps up: each byte costs a single digit accumulate (times ten plus digit)
// or a counter decrement, done combinationally between the parser state and the
// result register. A result sits in a one-entry output register and appears
// the cycle after its byte is taken. The next byte is accepted in the same
// cycle that result is taken. While a result waits untaken, no byte is
// accepted, even one that would give no result. Payload bytes come out as
// they arrive, the comma gives a
// completion with the length and the total byte count of the netstring, and
// any error is reported once, after which bytes are dropped up to the byte
// flagged is_last. A buffer that ends mid-frame reports an error on its last
// byte. max_payload_len may be rewritten only while the block is idle.
module netstring_stream_deframer
    import nsdf_pkg::*;
#(
    parameter int unsigned MAX_DIGITS = 9
) (
    input  logic             clk,
    input  logic             rst_n,
    // byte input
    input  logic             in_valid,
    output logic             in_ready,
    input  in_item_t         in_data,
    // result output
    output logic             out_valid,
    input  logic             out_ready,
    output out_item_t        out_data,
    // max_payload_len register
    input  logic             cfg_wr_en,
    input  logic [LEN_W-1:0] cfg_wr_data
);

    localparam int unsigned CNT_W = $clog2(MAX_DIGITS + 1);
    localparam logic [CNT_W-1:0] CNT_LIMIT = CNT_W'(MAX_DIGITS);
    localparam logic [CNT_W-1:0] CNT_ONE   = CNT_W'(1);

    // Parser state
    phase_t           phase_reg, phase_next;
    logic [LEN_W-1:0] acc_reg, acc_next;
    logic [CNT_W-1:0] digit_cnt_reg, digit_cnt_next;
    logic             zero_first_reg, zero_first_next;
    logic [LEN_W-1:0] remain_reg, remain_next;
    logic             over_reg, over_next;
    logic [LEN_W-1:0] max_len_reg;

    // Result register
    logic      out_valid_reg, out_valid_next;
    out_item_t out_data_reg, out_data_next;

    logic       in_xfer;
    logic [7:0] b;
    logic       last;
    logic       is_digit;
    logic [3:0] digit;
    logic [LEN_W+3:0] acc_mul;
    logic [LEN_W-1:0] acc_sat;
    logic             acc_ovf;
    logic             emit;
    out_item_t        res;

    assign in_ready = !out_valid_reg || out_ready;
    assign in_xfer  = in_valid && in_ready;
    assign b        = in_data.data_byte;
    assign last     = in_data.is_last;
    assign is_digit = (b >= CHAR_ZERO) && (b <= CHAR_NINE);
    assign digit    = 4'(b - CHAR_ZERO);

    // acc * 10 + digit with saturation at the field maximum
    assign acc_mul = {1'b0, acc_reg, 3'b000} + {3'b000, acc_reg, 1'b0} + (LEN_W+4)'(digit);
    assign acc_ovf = acc_mul > (LEN_W+4)'(LEN_MAX);
    assign acc_sat = acc_ovf ? LEN_MAX : acc_mul[LEN_W-1:0];

    // Config register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_len_reg <= LEN_RESET;
        end
        else if (cfg_wr_en)
        begin
            max_len_reg <= cfg_wr_data;
        end
    end

    // Next state and result for the accepted byte
    always_comb
    begin
        logic fail;
        logic new_frame;
        logic upd_big;
        status_t fail_st;

        fail      = 1'b0;
        new_frame = 1'b0;
        upd_big   = 1'b0;
        fail_st   = ST_FORMAT;

        phase_next      = phase_reg;
        acc_next        = acc_reg;
        digit_cnt_next  = digit_cnt_reg;
        zero_first_next = zero_first_reg;
        remain_next     = remain_reg;
        over_next       = over_reg;

        emit = 1'b0;
        res  = '{out_kind: KIND_NONE, payload_byte: 8'd0, status: ST_OK,
                 payload_length: '0, consumed_count: '0};

        unique case (phase_reg)
            PH_LEN:
            begin
                if (is_digit)
                begin
                    if (digit_cnt_reg >= CNT_LIMIT)
                    begin
                        fail = 1'b1;
                    end
                    else if (digit_cnt_reg == CNT_ONE && zero_first_reg)
                    begin
                        fail = 1'b1;
                    end
                    else
                    begin
                        if (digit_cnt_reg == '0)
                        begin
                            zero_first_next = (digit == 4'd0);
                        end
                        acc_next       = acc_sat;
                        over_next      = over_reg || acc_ovf;
                        digit_cnt_next = digit_cnt_reg + CNT_ONE;
                        // buffer ended inside the digit field
                        if (last)
                        begin
                            upd_big = over_next || (acc_next > max_len_reg);
                            fail    = 1'b1;
                            fail_st = upd_big ? ST_RANGE : ST_FORMAT;
                        end
                    end
                end
                else if (digit_cnt_reg == '0)
                begin
                    fail = 1'b1;
                end
                else if (over_reg || (acc_reg > max_len_reg))
                begin
                    fail    = 1'b1;
                    fail_st = ST_RANGE;
                end
                else if (b != CHAR_COLON || last)
                begin
                    fail = 1'b1;
                end
                else
                begin
                    remain_next = acc_reg;
                    phase_next  = (acc_reg == '0) ? PH_COMMA : PH_PAYLOAD;
                end
            end

            PH_PAYLOAD:
            begin
                if (last)
                begin
                    fail = 1'b1;
                end
                else
                begin
                    remain_next = remain_reg - LEN_W'(1);
                    if (remain_next == '0)
                    begin
                        phase_next = PH_COMMA;
                    end
                    emit             = 1'b1;
                    res.out_kind     = KIND_BYTE;
                    res.payload_byte = b;
                end
            end

            PH_COMMA:
            begin
                if (b != CHAR_COMMA)
                begin
                    fail = 1'b1;
                end
                else
                begin
                    emit               = 1'b1;
                    res.out_kind       = KIND_DONE;
                    res.payload_length = acc_reg;
                    res.consumed_count = LEN_W'(digit_cnt_reg) + acc_reg + LEN_W'(2);
                    new_frame          = 1'b1;
                end
            end

            PH_SKIP:
            begin
                new_frame = last;
            end

            default:
            begin
                new_frame = 1'b1;
            end
        endcase

        // Error report, then skip or restart
        if (fail)
        begin
            emit         = 1'b1;
            res.out_kind = KIND_ERR;
            res.status   = fail_st;
            if (last)
            begin
                new_frame = 1'b1;
            end
            else
            begin
                phase_next = PH_SKIP;
            end
        end

        if (new_frame)
        begin
            phase_next      = PH_LEN;
            acc_next        = '0;
            digit_cnt_next  = '0;
            zero_first_next = 1'b0;
            remain_next     = '0;
            over_next       = 1'b0;
        end
    end

    // Output register control
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (in_xfer)
        begin
            out_valid_next = emit;
            if (emit)
            begin
                out_data_next = res;
            end
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Parser state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_LEN;
            acc_reg        <= '0;
            digit_cnt_reg  <= '0;
            zero_first_reg <= 1'b0;
            remain_reg     <= '0;
            over_reg       <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (in_xfer)
            begin
                phase_reg      <= phase_next;
                acc_reg        <= acc_next;
                digit_cnt_reg  <= digit_cnt_next;
                zero_first_reg <= zero_first_next;
                remain_reg     <= remain_next;
                over_reg       <= over_next;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    // Result payload, no reset needed
    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // Checks
`include "assert_macros.svh"

    `ASSERT_SAME(a_no_empty_result, out_valid_reg, out_data_reg.out_kind != KIND_NONE, "empty result held")
    `ASSERT_SAME(a_payload_nonzero, phase_reg == PH_PAYLOAD, remain_reg != '0, "payload phase with zero left")
    `ASSERT_SAME(a_digit_bound, 1'b1, digit_cnt_reg <= CNT_LIMIT, "digit count past limit")
    `ASSERT_NEXT(a_last_restarts, in_xfer && last, phase_reg == PH_LEN && digit_cnt_reg == '0, "no restart after buffer end")
    `ASSERT_SAME(a_byte_clean, out_valid_reg && out_data_reg.out_kind == KIND_BYTE, out_data_reg.status == ST_OK && out_data_reg.payload_length == '0, "payload result carries stray fields")

endmodule

// ===== tb/nsdf_tb_pkg.sv =====
// ----------------------------------------------------------------------------
// nsdf_tb_pkg
// Scoreboard for the netstring stream deframer. It tracks the parse of each
// accepted byte and queues any result that byte must produce.
// ----------------------------------------------------------------------------
package nsdf_tb_pkg;

    import nsdf_pkg::*;

    localparam int unsigned LEN_DIGITS = 9;

    class deframe_scoreboard;

        // Parser state as the block should hold it
        phase_t           phase;
        logic [LEN_W-1:0] len_acc;
        logic [LEN_W-1:0] remaining;
        logic [LEN_W-1:0] max_len;
        int unsigned      digit_cnt;
        bit               first_zero;
        bit               len_over;

        out_item_t        expected_q[$];

        int unsigned      n_bytes;
        int unsigned      n_payload;
        int unsigned      n_frames;
        int unsigned      n_errors;
        int unsigned      n_mismatch;

        function new();
            max_len = LEN_RESET;
            start_frame();
        endfunction

        function void start_frame();
            phase      = PH_LEN;
            len_acc    = '0;
            digit_cnt  = 0;
            first_zero = 1'b0;
            remaining  = '0;
            len_over   = 1'b0;
        endfunction

        function void set_max_len(input logic [LEN_W-1:0] limit);
            max_len = limit;
        endfunction

        function int unsigned pending();
            return expected_q.size();
        endfunction

        function bit too_long();
            return len_over || (len_acc > max_len);
        endfunction

        function void queue_result(input kind_t kind, input logic [7:0] pb,
                                   input status_t st, input logic [LEN_W-1:0] plen,
                                   input logic [LEN_W-1:0] cons);
            out_item_t r;
            r.out_kind       = kind;
            r.payload_byte   = pb;
            r.status         = st;
            r.payload_length = plen;
            r.consumed_count = cons;
            expected_q.push_back(r);
        endfunction

        // Error: report once, then skip to the buffer end (or restart if
        // this is already the last byte)
        function void frame_error(input status_t st, input bit last);
            if (last)
                start_frame();
            else
                phase = PH_SKIP;
            n_errors++;
            queue_result(KIND_ERR, 8'h00, st, '0, '0);
        endfunction

        // Advance the parse by one accepted byte
        function void note_byte(input in_item_t item);
            logic [7:0]       b;
            bit               last;
            logic [7:0]       d;
            logic [LEN_W+3:0] acc;
            logic [31:0]      total;
            b    = item.data_byte;
            last = item.is_last;
            n_bytes++;
            case (phase)
                PH_LEN:
                begin
                    if (b >= CHAR_ZERO && b <= CHAR_NINE)
                    begin
                        d = b - CHAR_ZERO;
                        // too many digits, or a digit after a leading zero
                        if (digit_cnt >= LEN_DIGITS || (digit_cnt == 1 && first_zero))
                            frame_error(ST_FORMAT, last);
                        else
                        begin
                            if (digit_cnt == 0)
                                first_zero = (d == 0);
                            acc = len_acc * 10 + d;
                            if (acc > LEN_MAX)
                            begin
                                len_over = 1'b1;
                                acc      = LEN_MAX;
                            end
                            len_acc = acc[LEN_W-1:0];
                            digit_cnt++;
                            // buffer ends inside the length field
                            if (last)
                                frame_error(too_long() ? ST_RANGE : ST_FORMAT, 1'b1);
                        end
                    end
                    else if (digit_cnt == 0)
                        frame_error(ST_FORMAT, last);
                    else if (too_long())
                        frame_error(ST_RANGE, last);
                    else if (b != CHAR_COLON || last)
                        frame_error(ST_FORMAT, last);
                    else
                    begin
                        remaining = len_acc;
                        phase     = (len_acc == 0) ? PH_COMMA : PH_PAYLOAD;
                    end
                end
                PH_PAYLOAD:
                begin
                    // truncation replaces the payload output
                    if (last)
                        frame_error(ST_FORMAT, 1'b1);
                    else
                    begin
                        remaining = remaining - 1'b1;
                        if (remaining == 0)
                            phase = PH_COMMA;
                        n_payload++;
                        queue_result(KIND_BYTE, b, ST_OK, '0, '0);
                    end
                end
                PH_COMMA:
                begin
                    if (b != CHAR_COMMA)
                        frame_error(ST_FORMAT, last);
                    else
                    begin
                        total = digit_cnt + len_acc + 2;
                        queue_result(KIND_DONE, 8'h00, ST_OK, len_acc, total[LEN_W-1:0]);
                        n_frames++;
                        start_frame();
                    end
                end
                default:
                begin
                    if (last)
                        start_frame();
                end
            endcase
        endfunction

        // Compare one taken result with the oldest expectation
        function void check_output(input out_item_t got);
            out_item_t want;
            if (expected_q.size() == 0)
            begin
                $error("unexpected result: out_kind %0d", got.out_kind);
                n_mismatch++;
                return;
            end
            want = expected_q.pop_front();
            if (got.out_kind !== want.out_kind)
            begin
                $error("out_kind: expected %0d, got %0d", want.out_kind, got.out_kind);
                n_mismatch++;
            end
            if (got.payload_byte !== want.payload_byte)
            begin
                $error("payload_byte: expected %0d, got %0d",
                       want.payload_byte, got.payload_byte);
                n_mismatch++;
            end
            if (got.status !== want.status)
            begin
                $error("status: expected %0d, got %0d", want.status, got.status);
                n_mismatch++;
            end
            if (got.payload_length !== want.payload_length)
            begin
                $error("payload_length: expected %0d, got %0d",
                       want.payload_length, got.payload_length);
                n_mismatch++;
            end
            if (got.consumed_count !== want.consumed_count)
            begin
                $error("consumed_count: expected %0d, got %0d",
                       want.consumed_count, got.consumed_count);
                n_mismatch++;
            end
        endfunction

    endclass

endpackage

// ===== tb/netstring_stream_deframer_tb.sv =====
// ----------------------------------------------------------------------------
// netstring_stream_deframer_tb
// Drives byte buffers of well-formed, damaged and noisy netstrings into the
// deframer under changing length limits and idle patterns on both sides,
// and checks every result against a scoreboard that tracks the parse.
// ----------------------------------------------------------------------------
module netstring_stream_deframer_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import nsdf_pkg::*;
    import nsdf_tb_pkg::*;

    localparam int unsigned STALL_LIMIT   = 4000;
    localparam int unsigned SETTLE_CYCLES = 4;
    localparam int unsigned SEG_BYTES     = 170;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             in_valid = 1'b0;
    logic             in_ready;
    in_item_t         in_data = '0;
    logic             out_valid;
    logic             out_ready = 1'b0;
    out_item_t        out_data;
    logic             cfg_wr_en = 1'b0;
    logic [LEN_W-1:0] cfg_wr_data = '0;

    deframe_scoreboard sb = new();

    int unsigned tx_idle_pct = 0;
    int unsigned rx_idle_pct = 0;
    int unsigned bytes_sent = 0;
    int unsigned stall_cycles = 0;
    logic [7:0]  stream_bytes[$];

    netstring_stream_deframer #(
        .MAX_DIGITS (LEN_DIGITS)
    ) DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .in_data     (in_data),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_data    (out_data),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    // Transfer monitor: feed the scoreboard on both channels
    always @(posedge clk)
    begin
        if (rst_n && in_valid && in_ready)
            sb.note_byte(in_data);
        if (rst_n && out_valid && out_ready)
            sb.check_output(out_data);
    end

    // Receiver back-pressure
    always @(posedge clk)
    begin
        out_ready <= ($urandom_range(99) >= rx_idle_pct);
    end

    // Cycles without any transfer
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
    end

    initial
    begin
        while (stall_cycles < STALL_LIMIT)
            @(posedge clk);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // One byte transfer, with random gaps in front of it
    task send_byte(input logic [7:0] b, input bit last);
        in_item_t item;
        item.data_byte = b;
        item.is_last   = last;
        while ($urandom_range(99) < tx_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= item;
        do
            @(posedge clk);
        while (!in_ready);
        bytes_sent++;
    endtask

    // Send the queued buffer, flagging its final byte
    task send_buffer();
        int unsigned i;
        for (i = 0; i < stream_bytes.size(); i++)
            send_byte(stream_bytes[i], i == stream_bytes.size() - 1);
        stream_bytes.delete();
    endtask

    // Hold the sender until every expected result has come out
    task wait_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task set_max_len(input logic [LEN_W-1:0] limit);
        wait_idle();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= limit;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        sb.set_max_len(limit);
    endtask

    function void add_text(input string s);
        int i;
        for (i = 0; i < s.len(); i++)
            stream_bytes.push_back(s[i]);
    endfunction

    function void add_frame(input int unsigned len);
        add_text($sformatf("%0d", len));
        stream_bytes.push_back(CHAR_COLON);
        repeat (len) stream_bytes.push_back(8'($urandom_range(255)));
        stream_bytes.push_back(CHAR_COMMA);
    endfunction

    // Mostly well-formed frames, some cut short or damaged, some noise
    function void build_random_buffer();
        int unsigned pick;
        int unsigned cut;
        int unsigned pos;
        pick = $urandom_range(99);
        if (pick < 80)
        begin
            repeat ($urandom_range(1, 3))
                add_frame(($urandom_range(4) == 0) ? $urandom_range(9, 40)
                                                   : $urandom_range(0, 8));
            if (pick >= 55 && pick < 70 && stream_bytes.size() > 1)
            begin
                cut = $urandom_range(1, stream_bytes.size() - 1);
                while (stream_bytes.size() > cut)
                    void'(stream_bytes.pop_back());
            end
            else if (pick >= 70)
            begin
                pos = $urandom_range(stream_bytes.size() - 1);
                stream_bytes[pos] = 8'($urandom_range(255));
            end
        end
        else if (pick < 88)
        begin
            // wide length, buffer ends at the colon or early in the payload
            if ($urandom_range(3) == 0)
                stream_bytes.push_back(CHAR_ZERO);
            add_text($sformatf("%0d", $urandom_range(999999999)));
            stream_bytes.push_back(CHAR_COLON);
            repeat ($urandom_range(3)) stream_bytes.push_back(8'($urandom_range(255)));
        end
        else if (pick < 94)
        begin
            // more digits than the length field holds
            stream_bytes.push_back(8'($urandom_range(CHAR_ZERO + 1, CHAR_NINE)));
            repeat ($urandom_range(9, 11))
                stream_bytes.push_back(8'($urandom_range(CHAR_ZERO, CHAR_NINE)));
            stream_bytes.push_back(CHAR_COLON);
        end
        else
        begin
            repeat ($urandom_range(1, 6)) stream_bytes.push_back(8'($urandom_range(255)));
        end
    endfunction

    function logic [LEN_W-1:0] segment_limit(input int unsigned seg);
        case (seg)
            0:       return LEN_RESET;
            1:       return '0;
            2:       return LEN_W'($urandom_range(1, 40));
            default: return LEN_W'($urandom_range(999999999));
        endcase
    endfunction

    // Stimulus
    initial
    begin
        int unsigned tx_mix[3];
        int unsigned rx_mix[3];
        int unsigned ph;
        int unsigned seg;
        int unsigned target;
        tx_mix = '{24, 76, 0};
        rx_mix = '{76, 24, 0};
        tx_idle_pct = tx_mix[0];
        rx_idle_pct = rx_mix[0];
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty and two-byte frames with extreme payload values
        set_max_len(LEN_RESET);
        add_text("0:,2:");
        stream_bytes.push_back(8'h00);
        stream_bytes.push_back(8'hFF);
        stream_bytes.push_back(CHAR_COMMA);
        send_buffer();
        // leading zero, missing length, too many digits
        add_text("01:");
        send_buffer();
        add_text("x");
        send_buffer();
        add_text("1234567890");
        send_buffer();
        // buffer ends after digits, and inside the payload
        add_text("5");
        send_buffer();
        add_text("2:a");
        send_buffer();
        // wrong separator, wrong trailer
        add_text("1;");
        send_buffer();
        add_text("1:ab");
        send_buffer();
        // range errors at the colon and at the buffer end
        set_max_len('0);
        add_text("1:");
        send_buffer();
        add_text("7");
        send_buffer();

        // Random buffers over idle mixes and length limits
        for (ph = 0; ph < 3; ph++)
        begin
            tx_idle_pct = tx_mix[ph];
            rx_idle_pct = rx_mix[ph];
            for (seg = 0; seg < 4; seg++)
            begin
                set_max_len(segment_limit(seg));
                target = bytes_sent + SEG_BYTES;
                while (bytes_sent < target)
                begin
                    build_random_buffer();
                    send_buffer();
                end
            end
        end

        wait_idle();
        $display("Run covered %0d input bytes: %0d payload bytes, %0d frames, %0d errors.",
                 sb.n_bytes, sb.n_payload, sb.n_frames, sb.n_errors);
        $display("Length limits from zero to full range, three sender/receiver idle mixes.");
        if (sb.n_mismatch == 0 && sb.pending() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
